[design/rsa_pkg.sv]
package rsa_pkg;

   localparam int MOD_BITS_DEF = 20;
   localparam int CSR_IDX_W = 2;
   localparam int BYTE_MAX = 255;

   localparam logic [CSR_IDX_W-1:0] CSR_PUB_EXP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIV_EXP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS  = 2'd2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_REDUCE,
      MUL_ACC,
      MUL_SQUARE
   } mul_op_type;

endpackage

[design/rsa_byte_modexp_cipher_top.sv]
// Textbook RSA on one value per transfer: an encrypt request (tuser 0) raises the low byte
// of tdata to the public exponent modulo the modulus, a decrypt request (tuser 1) raises the
// whole value to the private exponent and flags a result above 255 in rsp_tuser. All work is
// done by one shift-add modular multiplier that retires one multiplier bit per cycle. An item
// first reduces the operand modulo the modulus with one product, then squares once per bit
// of the selected exponent's length and multiplies once per one bit of it; a zero modulus
// skips all products and gives zero. The request side is ready only between items; a finished
// result waits in an output register while the next request is taken. Configuration must be
// written through the csr port only while the block is idle; the block itself does not
// enforce this. Indexes 0, 1 and 2 select public exponent, private exponent and modulus.
module rsa_byte_modexp_cipher_top
   import rsa_pkg::*;
#(
   parameter int MOD_BITS = MOD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [CSR_IDX_W-1:0]            csr_index,
   input  logic [MOD_BITS-1:0]             csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: operand_value.
   input  logic [((MOD_BITS+7)/8)*8-1:0]   req_tdata,
   // Fields from bit 0: req_type.
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0: result_value.
   output logic [((MOD_BITS+7)/8)*8-1:0]   rsp_tdata,
   // Fields from bit 0: range_error.
   output logic                            rsp_tuser
);

   localparam int DATA_W = ((MOD_BITS+7)/8)*8;
   localparam int CNT_W = $clog2(MOD_BITS);

   state_type             state_ff, state_in;
   mul_op_type            mul_op_ff, mul_op_in;
   logic                  mul_done_ff, mul_done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [MOD_BITS-1:0]   pub_exp_ff, priv_exp_ff, modulus_ff;

   logic [MOD_BITS-1:0]   m_ff, m_in;
   logic [MOD_BITS-1:0]   exp_ff, exp_in;
   logic [MOD_BITS-1:0]   base_ff, base_in;
   logic [MOD_BITS-1:0]   acc_ff, acc_in;
   logic [MOD_BITS-1:0]   mul_a_ff, mul_a_in;
   logic [MOD_BITS-1:0]   mul_b_ff, mul_b_in;
   logic [MOD_BITS-1:0]   r_ff, r_in;
   logic                  dec_ff, dec_in;
   logic [MOD_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic [MOD_BITS:0]     dbl, dbl_red, sum, step_r;
   logic [MOD_BITS-1:0]   step_res;
   logic [MOD_BITS-1:0]   operand;
   logic                  run_last;
   logic                  out_free;

   // One step of the interleaved multiplier: r = 2r + bit * b, reduced modulo m.
   always_comb begin
      dbl      = {r_ff, 1'b0};
      dbl_red  = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum      = dbl_red + (mul_a_ff[MOD_BITS-1] ? {1'b0, mul_b_ff} : '0);
      step_r   = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
      step_res = step_r[MOD_BITS-1:0];
   end

   assign run_last = cnt_ff == CNT_W'(MOD_BITS - 1);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign operand  = (req_tuser == OP_DECRYPT) ? req_tdata[MOD_BITS-1:0]
                                               : req_tdata[MOD_BITS-1:0] & MOD_BITS'(BYTE_MAX);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (modulus_ff == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (run_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            state_in = (exp_ff == '0) ? ST_DONE : ST_RUN;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_op_in    = mul_op_ff;
      mul_done_in  = mul_done_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      exp_in       = exp_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      r_in         = r_ff;
      dec_in       = dec_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               m_in        = modulus_ff;
               dec_in      = req_tuser;
               exp_in      = (req_tuser == OP_DECRYPT) ? priv_exp_ff : pub_exp_ff;
               acc_in      = (modulus_ff == '0) ? '0 : MOD_BITS'(1);
               mul_a_in    = operand;
               mul_b_in    = MOD_BITS'(1);
               r_in        = '0;
               cnt_in      = '0;
               mul_op_in   = MUL_REDUCE;
               mul_done_in = 1'b0;
            end
         end
         ST_RUN: begin
            r_in     = step_res;
            mul_a_in = mul_a_ff << 1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (run_last) begin
               case (mul_op_ff)
                  MUL_ACC: acc_in = step_res;
                  default: base_in = step_res;
               endcase
            end
         end
         ST_NEXT: begin
            if (exp_ff != '0) begin
               r_in   = '0;
               cnt_in = '0;
               if (exp_ff[0] && !mul_done_ff) begin
                  mul_op_in   = MUL_ACC;
                  mul_a_in    = acc_ff;
                  mul_b_in    = base_ff;
                  mul_done_in = 1'b1;
               end else begin
                  mul_op_in   = MUL_SQUARE;
                  mul_a_in    = base_ff;
                  mul_b_in    = base_ff;
                  exp_in      = exp_ff >> 1;
                  mul_done_in = 1'b0;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = acc_ff;
               rsp_err_in   = (dec_ff == OP_DECRYPT) && (acc_ff > MOD_BITS'(BYTE_MAX));
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_op_ff    <= MUL_REDUCE;
         mul_done_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pub_exp_ff   <= '0;
         priv_exp_ff  <= '0;
         modulus_ff   <= MOD_BITS'(1);
      end else begin
         state_ff     <= state_in;
         mul_op_ff    <= mul_op_in;
         mul_done_ff  <= mul_done_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PUB_EXP:  pub_exp_ff  <= csr_wdata;
               CSR_PRIV_EXP: priv_exp_ff <= csr_wdata;
               CSR_MODULUS:  modulus_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      exp_ff      <= exp_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      r_ff        <= r_in;
      dec_ff      <= dec_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_err_ff;

`ifndef ASSERT_OFF
   a_partial_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && m_ff != '0) |-> (r_ff < m_ff))
      else $error("partial product not reduced below the modulus");

   a_base_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT && m_ff != '0) |-> (base_ff < m_ff))
      else $error("base not reduced below the modulus");

   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_data_ff > MOD_BITS'(BYTE_MAX)))
      else $error("range flag set on a result that fits in a byte");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request side ready again right after a transfer");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import rsa_pkg::*;

   localparam int VAL_W = MOD_BITS_DEF;
   localparam int DATA_W = ((VAL_W + 7) / 8) * 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             range_err;
   } cipher_result_type;

   // Keeps its own copy of the key registers and predicts one result per request.
   class modexp_scoreboard;
      logic [VAL_W-1:0]  public_exp;
      logic [VAL_W-1:0]  private_exp;
      logic [VAL_W-1:0]  modulus;
      cipher_result_type expected_q[$];
      int unsigned       errors;

      function new();
         public_exp = '0;
         private_exp = '0;
         modulus = VAL_W'(1);
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
         case (idx)
            CSR_PUB_EXP: begin
               public_exp = val;
            end
            CSR_PRIV_EXP: begin
               private_exp = val;
            end
            CSR_MODULUS: begin
               modulus = val;
            end
            default: begin
            end
         endcase
      endfunction

      // Right-to-left square and multiply; the accumulator starts at one unreduced.
      function logic [VAL_W-1:0] mod_power(logic [VAL_W-1:0] base,
                                           logic [VAL_W-1:0] exponent,
                                           logic [VAL_W-1:0] m);
         logic [63:0]      acc;
         logic [63:0]      b;
         logic [63:0]      m64;
         logic [VAL_W-1:0] x;
         if (m == 0) begin
            return '0;
         end
         m64 = 64'(m);
         acc = 64'd1;
         b = 64'(base) % m64;
         x = exponent;
         while (x != 0) begin
            if (x[0]) begin
               acc = (acc * b) % m64;
            end
            b = (b * b) % m64;
            x = x >> 1;
         end
         return acc[VAL_W-1:0];
      endfunction

      function void note_request(logic op, logic [VAL_W-1:0] operand);
         cipher_result_type r;
         if (op == OP_ENCRYPT) begin
            r.value = mod_power(VAL_W'(operand[7:0]), public_exp, modulus);
            r.range_err = 1'b0;
         end else begin
            r.value = mod_power(operand, private_exp, modulus);
            r.range_err = (r.value > BYTE_MAX);
         end
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void check_response(logic [VAL_W-1:0] value, logic range_err);
         cipher_result_type r;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("Unexpected result transfer: value %h range_error %b", value, range_err);
            end
            return;
         end
         r = expected_q.pop_front();
         if (r.value !== value || r.range_err !== range_err) begin
            errors++;
            if (errors <= 10) begin
               $display({"Result mismatch: expected value %h range_error %b, ",
                         "got value %h range_error %b"},
                        r.value, r.range_err, value, range_err);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VAL_W-1:0]     csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;

   modexp_scoreboard sb;
   int unsigned      send_idle_pct = 0;
   int unsigned      rsp_stall_pct = 0;
   int unsigned      hold_requests = 0;
   int unsigned      hold_served = 0;
   int unsigned      hold_left = 0;

   rsa_byte_modexp_cipher_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // The result side either stalls at random or sits out a requested long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= 4000;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tuser, req_tdata[VAL_W-1:0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata[VAL_W-1:0], rsp_tuser);
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input logic op, input logic [VAL_W-1:0] operand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= DATA_W'(operand);
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] rand_exponent();
      case ($urandom_range(7))
         0: return '0;
         1: return VAL_MAX;
         default: return VAL_W'($urandom_range(VAL_MAX)) >> $urandom_range(VAL_W - 1);
      endcase
   endfunction

   task automatic random_config();
      logic [VAL_W-1:0] m;
      case ($urandom_range(6))
         0: m = VAL_MAX;
         1: m = 20'd3233;
         2: m = 20'd1;
         3: m = VAL_W'($urandom_range(255, 2));
         default: m = VAL_W'($urandom_range(VAL_MAX, 2));
      endcase
      write_reg(CSR_MODULUS, m);
      write_reg(CSR_PUB_EXP, rand_exponent());
      write_reg(CSR_PRIV_EXP, rand_exponent());
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                            input int n_items, input bit with_pressure);
      logic             op;
      logic [VAL_W-1:0] operand;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         op = ($urandom_range(1) == 0) ? OP_ENCRYPT : OP_DECRYPT;
         case ($urandom_range(9))
            0: operand = '0;
            1: operand = VAL_MAX;
            2: operand = sb.modulus - VAL_W'(1);
            3: operand = sb.modulus;
            default: operand = VAL_W'($urandom_range(VAL_MAX));
         endcase
         send_item(op, operand);
         if (with_pressure && i == n_items / 3) begin
            hold_requests++;
         end
         if (with_pressure && i == (2 * n_items) / 3) begin
            wait_idle();
         end
      end
      wait_idle();
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset keys: exponent zero gives one even with modulus one.
      send_item(OP_ENCRYPT, VAL_MAX);
      send_item(OP_DECRYPT, '0);
      wait_idle();

      write_reg(CSR_PUB_EXP, 20'd17);
      write_reg(CSR_PRIV_EXP, 20'd2753);
      write_reg(CSR_MODULUS, 20'd3233);
      send_item(OP_ENCRYPT, '0);
      send_item(OP_ENCRYPT, 20'd255);
      send_item(OP_ENCRYPT, 20'hABC41);
      send_item(OP_DECRYPT, '0);
      send_item(OP_DECRYPT, 20'd3232);
      send_item(OP_DECRYPT, 20'd3233);
      send_item(OP_DECRYPT, VAL_MAX);
      send_item(OP_DECRYPT, 20'd2790);
      wait_idle();

      write_reg(CSR_UNUSED, 20'h12345);
      send_item(OP_ENCRYPT, 20'd2);
      wait_idle();

      write_reg(CSR_MODULUS, '0);
      send_item(OP_ENCRYPT, 20'h000FF);
      send_item(OP_DECRYPT, VAL_MAX);
      wait_idle();

      write_reg(CSR_MODULUS, VAL_MAX);
      write_reg(CSR_PUB_EXP, VAL_MAX);
      write_reg(CSR_PRIV_EXP, VAL_MAX);
      send_item(OP_ENCRYPT, 20'd255);
      send_item(OP_DECRYPT, VAL_MAX);
      send_item(OP_DECRYPT, 20'd1);
      wait_idle();

      write_reg(CSR_PUB_EXP, '0);
      write_reg(CSR_PRIV_EXP, '0);
      send_item(OP_ENCRYPT, 20'd7);
      send_item(OP_DECRYPT, 20'h80000);
      wait_idle();

      write_reg(CSR_MODULUS, 20'd1);
      write_reg(CSR_PRIV_EXP, 20'd5);
      send_item(OP_DECRYPT, VAL_MAX);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         random_config();
         case (p % 4)
            0: run_phase(0, 0, 48, 1'b1);
            1: run_phase(69, 0, 48, 1'b0);
            2: run_phase(0, 69, 48, 1'b0);
            default: run_phase(20, 20, 48, 1'b0);
         endcase
      end

      wait_idle();
      repeat (1000) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
